@@ src/fps_pkg.sv @@
// ----------------------------------------------------------------------------
// Farthest point sampler package
// Sizes, codes and shared types of the farthest point sampler.
// ----------------------------------------------------------------------------
package fps_pkg;

	// Store depth and coordinate width.
	localparam int MAX_POINTS = 4096;
	localparam int COORD_W    = 16;

	// Derived widths.
	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W   = 2 * COORD_W;
	localparam int DIST_W = 2 * COORD_W + 2;
	localparam int PT_W   = 3 * COORD_W;

	// Fixed field widths of the register and result words.
	localparam int NS_W       = 13;
	localparam int START_W    = 12;
	localparam int SAMPLE_W   = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int CMP_W      = (CNT_W > NS_W) ? CNT_W : NS_W;

	localparam logic [DIST_W-1:0] DIST_ONES      = '1;
	localparam logic [NS_W-1:0]   NUM_SAMPLES_RST = NS_W'(1024);

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_STEP = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_SAMPLES = 1'b0,
		REG_START_INDEX = 1'b1
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	// One stored point on its way into the distance unit.
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [IDX_W-1:0]  idx;
		point_t            pt;
		logic [DIST_W-1:0] md;
	} dist_req_t;

	// Updated minimum distance of one point.
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] dsq;
	} dist_rsp_t;

	// Outcome of one sweep.
	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] pick;
	} amax_res_t;

endpackage

@@ src/fps_in_if.sv @@
// ----------------------------------------------------------------------------
// Input channel
// Carries load and step words into the sampler.
// ----------------------------------------------------------------------------
interface fps_in_if import fps_pkg::*;;
	logic   valid;
	logic   ready;
	func_t  func;
	coord_t coord_x;
	coord_t coord_y;
	coord_t coord_z;

	modport source (output valid, func, coord_x, coord_y, coord_z, input ready);
	modport sink   (input valid, func, coord_x, coord_y, coord_z, output ready);
endinterface

@@ src/fps_out_if.sv @@
// ----------------------------------------------------------------------------
// Output channel
// Carries one result word per step word.
// ----------------------------------------------------------------------------
interface fps_out_if import fps_pkg::*;;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_index;
	coord_t              out_x;
	coord_t              out_y;
	coord_t              out_z;
	logic                last_sample;
	logic                status;

	modport source (output valid, sample_index, out_x, out_y, out_z, last_sample, status,
		input ready);
	modport sink   (input valid, sample_index, out_x, out_y, out_z, last_sample, status,
		output ready);
endinterface

@@ src/fps_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration channel
// Register writes into the sampler.
// ----------------------------------------------------------------------------
interface fps_cfg_if import fps_pkg::*;;
	logic                  valid;
	logic                  ready;
	cfg_reg_t              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ src/fps_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/fps_dist_unit.sv @@
// ----------------------------------------------------------------------------
// Distance unit
// Three-stage pipeline: coordinate differences, squares, then sum and minimum.
// ----------------------------------------------------------------------------
module fps_dist_unit import fps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dist_req_t din,
	input  point_t    ref_pt,
	output dist_rsp_t dout
);

	logic                     vld_s1, vld_s2, vld_s3;
	logic                     last_s1, last_s2, last_s3;
	logic [IDX_W-1:0]         idx_s1, idx_s2, idx_s3;
	logic [DIST_W-1:0]        md_s1, md_s2;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [SQ_W-1:0]          sx_s2, sy_s2, sz_s2;
	logic [DIST_W-1:0]        dist_s3;

	logic [DIFF_W-1:0]          dx, dy, dz;
	logic signed [2*DIFF_W-1:0] px, py, pz;
	logic [DIST_W-1:0]          sum;

	// Sign-extend both operands by one bit; the difference always fits.
	assign dx = {din.pt.x[COORD_W-1], din.pt.x} - {ref_pt.x[COORD_W-1], ref_pt.x};
	assign dy = {din.pt.y[COORD_W-1], din.pt.y} - {ref_pt.y[COORD_W-1], ref_pt.y};
	assign dz = {din.pt.z[COORD_W-1], din.pt.z} - {ref_pt.z[COORD_W-1], ref_pt.z};

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	assign sum = DIST_W'(sx_s2) + DIST_W'(sy_s2) + DIST_W'(sz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= din.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= din.last;
		idx_s1  <= din.idx;
		md_s1   <= din.md;
		dx_s1   <= $signed(dx);
		dy_s1   <= $signed(dy);
		dz_s1   <= $signed(dz);

		last_s2 <= last_s1;
		idx_s2  <= idx_s1;
		md_s2   <= md_s1;
		sx_s2   <= px[SQ_W-1:0];
		sy_s2   <= py[SQ_W-1:0];
		sz_s2   <= pz[SQ_W-1:0];

		last_s3 <= last_s2;
		idx_s3  <= idx_s2;
		dist_s3 <= (sum < md_s2) ? sum : md_s2;
	end

	assign dout.valid = vld_s3;
	assign dout.last  = last_s3;
	assign dout.idx   = idx_s3;
	assign dout.dsq   = dist_s3;

endmodule

@@ src/fps_argmax.sv @@
// ----------------------------------------------------------------------------
// Running maximum
// Tracks the largest updated distance of a sweep, lowest index on ties.
// ----------------------------------------------------------------------------
module fps_argmax import fps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dist_rsp_t din,
	output amax_res_t res
);

	logic              done_q;
	logic [IDX_W-1:0]  pick_q;
	logic [DIST_W-1:0] best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= din.valid && din.last;
		end
	end

	// The first point of a sweep always seeds the maximum.
	always_ff @(posedge clk) begin
		if (din.valid && (din.idx == '0 || din.dsq > best_q)) begin
			best_q <= din.dsq;
			pick_q <= din.idx;
		end
	end

	assign res.done = done_q;
	assign res.pick = pick_q;

endmodule

@@ src/farthest_point_sampler.sv @@
// ----------------------------------------------------------------------------
// Farthest point sampler
// Stores a point cloud and returns one sample per step word: an empty status,
// the start point, a stored point in order, or the point farthest from the
// samples so far. A load word leaves the input ready; a step word holds it
// until its result enters the output register. A farthest point step sweeps the
// whole store: the distance unit walks the point memory one point per cycle.
// A result still waiting on the output holds the next step at its end.
// Reset clears the control state only; the memories are not cleared.
// ----------------------------------------------------------------------------
module farthest_point_sampler import fps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	fps_in_if.sink    req,
	fps_out_if.source rsp,
	fps_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REF_RD,
		ST_REF_LATCH,
		ST_SWEEP,
		ST_DRAIN,
		ST_PICK_RD,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [NS_W-1:0]    num_samples_q;
	logic [START_W-1:0] start_index_q;

	// Cloud and set bookkeeping.
	logic [CNT_W-1:0] point_count_q;
	logic [CNT_W-1:0] samples_emitted_q;
	logic [IDX_W-1:0] prev_pick_q;
	logic             last_q;
	logic             none_q;

	// Sweep control and the reference point of the current sweep.
	logic [IDX_W-1:0] sweep_idx_q;
	point_t           ref_q;
	logic             rd_vld_q;
	logic             rd_last_q;
	logic [IDX_W-1:0] rd_idx_q;

	// Output register.
	logic                rsp_vld_q;
	logic [SAMPLE_W-1:0] rsp_idx_q;
	coord_t              rsp_x_q, rsp_y_q, rsp_z_q;
	logic                rsp_last_q;
	logic                rsp_status_q;

	// Memory ports.
	logic              pt_wr_en, pt_rd_en;
	logic [IDX_W-1:0]  pt_rd_addr;
	logic [PT_W-1:0]   pt_wr_data, pt_rd_data;
	logic              md_wr_en, md_rd_en;
	logic [IDX_W-1:0]  md_wr_addr;
	logic [DIST_W-1:0] md_wr_data, md_rd_data;

	dist_req_t dist_req;
	dist_rsp_t dist_rsp;
	amax_res_t amax_res;
	point_t    rd_pt;

	logic             accept, is_step, load_wr, emit_go;
	logic [CNT_W-1:0] load_pc, se_inc, pc_m1;
	logic [CMP_W-1:0] pc_ext, ns_ext;
	logic             empty, in_order, exhausted, last_next, sweep_last;
	logic [IDX_W-1:0] start_pick;

	// ------------------------------------------------------------------
	// Step decisions. They are all made in the cycle a word is accepted;
	// only a farthest point step needs a sweep over the whole store.
	// ------------------------------------------------------------------
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_step   = (req.func == FUNC_STEP);

	// A load after any sample starts a new cloud at index zero.
	assign load_pc = (samples_emitted_q != '0) ? '0 : point_count_q;
	assign load_wr = accept && !is_step && (load_pc < CNT_W'(MAX_POINTS));

	assign pc_ext    = CMP_W'(point_count_q);
	assign ns_ext    = CMP_W'(num_samples_q);
	assign se_inc    = samples_emitted_q + CNT_W'(1);
	assign pc_m1     = point_count_q - CNT_W'(1);
	assign empty     = (point_count_q == '0) || (num_samples_q == '0);
	assign in_order  = (pc_ext <= ns_ext);
	assign exhausted = in_order ? (samples_emitted_q >= point_count_q)
		: (CMP_W'(samples_emitted_q) >= ns_ext);
	assign last_next = in_order ? (se_inc == point_count_q) : (CMP_W'(se_inc) == ns_ext);

	// The start point is clamped to the last stored point.
	assign start_pick = (CMP_W'(start_index_q) < pc_ext) ? IDX_W'(start_index_q)
		: IDX_W'(pc_m1);

	assign sweep_last = (CNT_W'(sweep_idx_q) == pc_m1);

	// The finished result moves into the output register once that is free.
	assign emit_go = (state_q == ST_EMIT) && (!rsp_vld_q || rsp.ready);

	// ------------------------------------------------------------------
	// Point memory: written by loads, read for the reference point, for
	// every point of a sweep and for the selected point.
	// ------------------------------------------------------------------
	assign pt_wr_en   = load_wr;
	assign pt_wr_data = {req.coord_x, req.coord_y, req.coord_z};
	assign pt_rd_en   = (state_q == ST_REF_RD) || (state_q == ST_SWEEP) ||
		(state_q == ST_PICK_RD);
	assign pt_rd_addr = (state_q == ST_SWEEP) ? sweep_idx_q : prev_pick_q;
	assign rd_pt      = pt_rd_data;

	fps_ram #(
		.WIDTH (PT_W),
		.DEPTH (MAX_POINTS)
	) u_point_ram (
		.clk     (clk),
		.wr_en   (pt_wr_en),
		.wr_addr (IDX_W'(load_pc)),
		.wr_data (pt_wr_data),
		.rd_en   (pt_rd_en),
		.rd_addr (pt_rd_addr),
		.rd_data (pt_rd_data)
	);

	// ------------------------------------------------------------------
	// Distance memory: a load marks its point as not yet reached, and a
	// sweep writes back each point's new minimum from the distance unit.
	// The two never meet, since loads are taken only while idle. Entries
	// past the point count are never read, so no clearing pass is needed.
	// ------------------------------------------------------------------
	assign md_wr_en   = load_wr || dist_rsp.valid;
	assign md_wr_addr = load_wr ? IDX_W'(load_pc) : dist_rsp.idx;
	assign md_wr_data = load_wr ? DIST_ONES : dist_rsp.dsq;
	assign md_rd_en   = (state_q == ST_SWEEP);

	fps_ram #(
		.WIDTH (DIST_W),
		.DEPTH (MAX_POINTS)
	) u_dist_ram (
		.clk     (clk),
		.wr_en   (md_wr_en),
		.wr_addr (md_wr_addr),
		.wr_data (md_wr_data),
		.rd_en   (md_rd_en),
		.rd_addr (sweep_idx_q),
		.rd_data (md_rd_data)
	);

	// ------------------------------------------------------------------
	// Distance pipeline and running maximum.
	// ------------------------------------------------------------------
	assign dist_req.valid = rd_vld_q;
	assign dist_req.last  = rd_last_q;
	assign dist_req.idx   = rd_idx_q;
	assign dist_req.pt    = rd_pt;
	assign dist_req.md    = md_rd_data;

	fps_dist_unit u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (dist_req),
		.ref_pt (ref_q),
		.dout   (dist_rsp)
	);

	fps_argmax u_argmax (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (dist_rsp),
		.res    (amax_res)
	);

	// ------------------------------------------------------------------
	// Configuration writes: the user sends them only while idle; unenforced.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_samples_q <= NUM_SAMPLES_RST;
			start_index_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_NUM_SAMPLES: num_samples_q <= cfg.data;
				REG_START_INDEX: start_index_q <= cfg.data[START_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer. A farthest point step reads the previous pick as the
	// reference, streams every stored point through the distance unit,
	// waits for the running maximum, then reads the winner's coordinates.
	// Other steps go straight to reading their pick or to an empty result.
	// The result waits in the output register while loads go on.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			point_count_q     <= '0;
			samples_emitted_q <= '0;
			prev_pick_q       <= '0;
			last_q            <= 1'b0;
			none_q            <= 1'b0;
			sweep_idx_q       <= '0;
			ref_q             <= '0;
			rd_vld_q          <= 1'b0;
			rd_last_q         <= 1'b0;
			rd_idx_q          <= '0;
			rsp_vld_q         <= 1'b0;
			rsp_idx_q         <= '0;
			rsp_x_q           <= '0;
			rsp_y_q           <= '0;
			rsp_z_q           <= '0;
			rsp_last_q        <= 1'b0;
			rsp_status_q      <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == ST_SWEEP);
			if (emit_go) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && !is_step) begin
						samples_emitted_q <= '0;
						point_count_q     <= load_wr ? load_pc + CNT_W'(1) : load_pc;
					end else if (accept) begin
						if (empty || exhausted) begin
							none_q  <= 1'b1;
							last_q  <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							none_q            <= 1'b0;
							samples_emitted_q <= se_inc;
							last_q            <= last_next;
							if (in_order) begin
								prev_pick_q <= IDX_W'(samples_emitted_q);
								state_q     <= ST_PICK_RD;
							end else if (samples_emitted_q == '0) begin
								prev_pick_q <= start_pick;
								state_q     <= ST_PICK_RD;
							end else begin
								state_q <= ST_REF_RD;
							end
						end
					end
				end
				ST_REF_RD: begin
					state_q <= ST_REF_LATCH;
				end
				ST_REF_LATCH: begin
					ref_q       <= rd_pt;
					sweep_idx_q <= '0;
					state_q     <= ST_SWEEP;
				end
				ST_SWEEP: begin
					rd_idx_q    <= sweep_idx_q;
					rd_last_q   <= sweep_last;
					sweep_idx_q <= sweep_idx_q + IDX_W'(1);
					if (sweep_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (amax_res.done) begin
						prev_pick_q <= amax_res.pick;
						state_q     <= ST_PICK_RD;
					end
				end
				ST_PICK_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// The point memory output still holds the pick.
					if (emit_go) begin
						rsp_status_q <= none_q;
						rsp_last_q   <= last_q;
						if (none_q) begin
							rsp_idx_q <= '0;
							rsp_x_q   <= '0;
							rsp_y_q   <= '0;
							rsp_z_q   <= '0;
						end else begin
							rsp_idx_q <= SAMPLE_W'(prev_pick_q);
							rsp_x_q   <= rd_pt.x;
							rsp_y_q   <= rd_pt.y;
							rsp_z_q   <= rd_pt.z;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.sample_index = rsp_idx_q;
	assign rsp.out_x        = rsp_x_q;
	assign rsp.out_y        = rsp_y_q;
	assign rsp.out_z        = rsp_z_q;
	assign rsp.last_sample  = rsp_last_q;
	assign rsp.status       = rsp_status_q;

endmodule

@@ src/fps_checker.sv @@
// ----------------------------------------------------------------------------
// Sampler checker
// Port-level properties of the farthest point sampler.
// ----------------------------------------------------------------------------
module fps_checker import fps_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input func_t               req_func,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [SAMPLE_W-1:0] rsp_sample_index,
	input coord_t              rsp_out_x,
	input coord_t              rsp_out_y,
	input coord_t              rsp_out_z,
	input logic                rsp_last_sample,
	input logic                rsp_status
);

	// A stalled result word keeps its valid and its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_index) &&
		$stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z) &&
		$stable(rsp_last_sample) && $stable(rsp_status))
		else $error("result word changed while stalled");

	// A step word takes the input out of ready once it is accepted.
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == FUNC_STEP |=> !req_ready)
		else $error("input ready right after a step word");

	// A load leaves the input ready in the cycle after it is accepted.
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == FUNC_LOAD |=> req_ready)
		else $error("input not ready after a load word");

	// An empty result carries nothing but its status.
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_sample_index == '0 && rsp_out_x == '0 &&
		rsp_out_y == '0 && rsp_out_z == '0 && !rsp_last_sample)
		else $error("empty result with nonzero fields");

endmodule

bind farthest_point_sampler fps_checker u_fps_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_func         (req.func),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_sample_index (rsp.sample_index),
	.rsp_out_x        (rsp.out_x),
	.rsp_out_y        (rsp.out_y),
	.rsp_out_z        (rsp.out_z),
	.rsp_last_sample  (rsp.last_sample),
	.rsp_status       (rsp.status)
);
